>>> rtl/pal_pkg.sv
// Shared constants, operation and status codes, and the cell command type
// for the positional array list. Depends on nothing.
`default_nettype none

package pal_pkg;

	// List size and derived widths
	localparam int CAPACITY   = 64;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	// Fixed field widths of the channels
	localparam int OP_W       = 3;
	localparam int POS_W      = 7;
	localparam int DATA_W     = 32;
	localparam int STAT_W     = 2;
	localparam int LEN_W      = 7;

	// Compare width that holds both a position and a count, plus one
	localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	// Result collection tree: first level groups of GROUP_N cells
	localparam int GROUP_N    = 8;
	localparam int GIDX_W     = $clog2(GROUP_N);
	localparam int NUM_GROUPS = (CAPACITY + GROUP_N - 1) / GROUP_N;
	localparam int PAD_N      = NUM_GROUPS * GROUP_N;

	// Operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
	localparam logic [OP_W-1:0] OP_GET    = 3'd2;
	localparam logic [OP_W-1:0] OP_LOCATE = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;

	// Command broadcast to every cell of the row
	typedef struct packed {
		logic              eval;      // capture read and match flags this cycle
		logic              ins;       // insert accepted: shift up from position
		logic              del;       // delete accepted: shift down into position
		logic [POS_W-1:0]  position;  // 1-based position of the operation
		logic [DATA_W-1:0] value;     // value to insert or to search for
		logic [CNT_W-1:0]  count;     // list length before the operation
	} cell_cmd_t;

endpackage

`default_nettype wire

>>> rtl/pal_ifs.sv
// Valid/ready channel interfaces for the positional array list: one for
// command beats and one for result beats. Depends on pal_pkg.
`default_nettype none

interface pal_in_if;
	import pal_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [POS_W-1:0]  position;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, operation, position, value, input ready);
	modport sink   (input valid, operation, position, value, output ready);
endinterface

interface pal_out_if;
	import pal_pkg::*;

	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic signed [DATA_W-1:0] read_value;
	logic [POS_W-1:0]  found_position;
	logic [LEN_W-1:0]  list_length;
	logic              is_empty;

	modport source (output valid, status, read_value, found_position, list_length,
		is_empty, input ready);
	modport sink   (input valid, status, read_value, found_position, list_length,
		is_empty, output ready);
endinterface

`default_nettype wire

>>> rtl/positional_array_list.sv
// Top level of the positional array list: command decode, list length,
// row of storage cells, result tree and output register.
// Depends on pal_pkg, pal_ifs, pal_cell and pal_group.
`default_nettype none

// A bounded ordered list of up to CAPACITY signed 32-bit entries kept in a
// row of cells that shift together. Each command beat (insert, delete, get,
// locate or clear at a 1-based position) yields exactly one result beat with
// status, the read or removed value, the first match position of a locate,
// and the length after the operation. Each command passes through the
// sequencer states in order: idle, where its beat is taken; eval, where every
// cell shifts and raises its read and match flags; and red1 and red2, where the
// registered tree collects those flags across the row. At the end of red2 the
// result enters the output register. A new command is accepted as soon as the
// previous one has left the tree, even while its result still waits to be
// taken; the result register only holds the block when an older result has
// not been taken yet. Reset clears the length; stored entries need no clearing.
module positional_array_list (
	input  wire logic    clk,
	input  wire logic    arst_n,
	pal_in_if.sink       cmd,
	pal_out_if.source    res
);
	import pal_pkg::*;

	// Sequencer codes
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EVAL = 2'd1;
	localparam logic [1:0] S_RED1 = 2'd2;
	localparam logic [1:0] S_RED2 = 2'd3;

	logic [1:0]         state_q;
	logic [OP_W-1:0]    op_q;
	logic [POS_W-1:0]   pos_q;
	logic [DATA_W-1:0]  val_q;
	logic [CNT_W-1:0]   count_q;
	logic [STAT_W-1:0]  status_s1;

	logic               cmd_fire;
	logic               eval;
	logic               finish;
	logic [CMP_W-1:0]   pos_w;
	logic [CMP_W-1:0]   cnt_w;
	logic [STAT_W-1:0]  status_c;
	logic [CNT_W-1:0]   count_next;
	cell_cmd_t          cell_cmd;

	logic [CAPACITY-1:0][DATA_W-1:0] entry_w;
	logic [PAD_N-1:0][DATA_W-1:0]    sel_pad;
	logic [PAD_N-1:0]                match_pad;
	logic [NUM_GROUPS-1:0][DATA_W-1:0] grp_data;
	logic [NUM_GROUPS-1:0]             grp_hit;
	logic [NUM_GROUPS-1:0][GIDX_W-1:0] grp_idx;

	logic [DATA_W-1:0]  tree_data;
	logic               tree_hit;
	logic [CNT_W-1:0]   tree_found;
	logic [DATA_W-1:0]  rd_c;
	logic [CNT_W-1:0]   found_c;

	logic               res_valid_q;
	logic [STAT_W-1:0]  res_status_q;
	logic [DATA_W-1:0]  res_read_q;
	logic [POS_W-1:0]   res_found_q;
	logic [LEN_W-1:0]   res_len_q;
	logic               res_empty_q;

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign eval      = (state_q == S_EVAL);
	assign finish    = (state_q == S_RED2) && (!res_valid_q || res.ready);

	// Sequencer: capture, cell update, two tree stages, then the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: state_q <= S_RED1;
				S_RED1: state_q <= S_RED2;
				S_RED2: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command capture
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			op_q  <= cmd.operation;
			pos_q <= cmd.position;
			val_q <= cmd.value;
		end
	end

	// Status and next length, decided from the length before the operation.
	assign pos_w = CMP_W'(pos_q);
	assign cnt_w = CMP_W'(count_q);

	always_comb begin
		status_c   = ST_OK;
		count_next = count_q;
		priority if (op_q == OP_INSERT) begin
			if (count_q >= CNT_W'(CAPACITY)) begin
				status_c = ST_FULL;
			end else if (pos_q == '0 || pos_w > cnt_w + CMP_W'(1)) begin
				status_c = ST_BADPOS;
			end else begin
				count_next = count_q + CNT_W'(1);
			end
		end else if (op_q == OP_DELETE) begin
			if (pos_q == '0 || pos_w > cnt_w) begin
				status_c = ST_BADPOS;
			end else begin
				count_next = count_q - CNT_W'(1);
			end
		end else if (op_q == OP_GET) begin
			if (pos_q == '0 || pos_w > cnt_w) begin
				status_c = ST_BADPOS;
			end
		end else if (op_q == OP_CLEAR) begin
			count_next = '0;
		end else begin
			status_c = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (eval) begin
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (eval) begin
			status_s1 <= status_c;
		end
	end

	// Command broadcast to the row
	always_comb begin
		cell_cmd.eval     = eval;
		cell_cmd.ins      = eval && (op_q == OP_INSERT) && (status_c == ST_OK);
		cell_cmd.del      = eval && (op_q == OP_DELETE) && (status_c == ST_OK);
		cell_cmd.position = pos_q;
		cell_cmd.value    = val_q;
		cell_cmd.count    = count_q;
	end

	// Row of cells; the ends take harmless neighbors.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] lower_w;
		logic [DATA_W-1:0] upper_w;

		if (i == 0) begin : g_first
			assign lower_w = '0;
		end else begin : g_inner_lo
			assign lower_w = entry_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign upper_w = entry_w[i];
		end else begin : g_inner_hi
			assign upper_w = entry_w[i+1];
		end

		pal_cell u_cell (
			.clk      (clk),
			.cmd      (cell_cmd),
			.index    (IDX_W'(i)),
			.lower    (lower_w),
			.upper    (upper_w),
			.entry    (entry_w[i]),
			.sel_data (sel_pad[i]),
			.match    (match_pad[i])
		);
	end

	// Padding of the last group when the row is not a whole number of groups
	for (genvar j = CAPACITY; j < PAD_N; j++) begin : g_pad
		assign sel_pad[j]   = '0;
		assign match_pad[j] = 1'b0;
	end

	// First tree level
	for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
		pal_group u_group (
			.clk      (clk),
			.data     (sel_pad[g*GROUP_N +: GROUP_N]),
			.hit      (match_pad[g*GROUP_N +: GROUP_N]),
			.data_out (grp_data[g]),
			.any_hit  (grp_hit[g]),
			.hit_idx  (grp_idx[g])
		);
	end

	// Second tree level: merge group data and pick the lowest matching group.
	always_comb begin
		tree_data  = '0;
		tree_hit   = 1'b0;
		tree_found = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			tree_data = tree_data | grp_data[g];
		end
		for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
			if (grp_hit[g]) begin
				tree_hit   = 1'b1;
				tree_found = CNT_W'(g * GROUP_N) + CNT_W'(grp_idx[g]) + CNT_W'(1);
			end
		end
	end

	// Only a successful get or delete returns data; only locate reports a match.
	always_comb begin
		rd_c    = '0;
		found_c = '0;
		if ((op_q == OP_GET || op_q == OP_DELETE) && status_s1 == ST_OK) begin
			rd_c = tree_data;
		end
		if (op_q == OP_LOCATE && tree_hit) begin
			found_c = tree_found;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (finish) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			res_status_q <= status_s1;
			res_read_q   <= rd_c;
			res_found_q  <= POS_W'(found_c);
			res_len_q    <= LEN_W'(count_q);
			res_empty_q  <= (count_q == '0);
		end
	end

	assign res.valid          = res_valid_q;
	assign res.status         = res_status_q;
	assign res.read_value     = res_read_q;
	assign res.found_position = res_found_q;
	assign res.list_length    = res_len_q;
	assign res.is_empty       = res_empty_q;

endmodule

`default_nettype wire

>>> rtl/pal_cell.sv
// One storage cell of the list row: holds one entry, shifts with its
// neighbors on insert and delete, and flags read selection and match.
// Depends on pal_pkg.
`default_nettype none

module pal_cell (
	input  wire logic                      clk,
	input  wire pal_pkg::cell_cmd_t        cmd,
	input  wire logic [pal_pkg::IDX_W-1:0] index,
	input  wire logic [pal_pkg::DATA_W-1:0] lower,
	input  wire logic [pal_pkg::DATA_W-1:0] upper,
	output logic [pal_pkg::DATA_W-1:0]     entry,
	output logic [pal_pkg::DATA_W-1:0]     sel_data,
	output logic                           match
);
	import pal_pkg::*;

	logic [DATA_W-1:0] entry_q;
	logic [DATA_W-1:0] sel_data_s1;
	logic              match_s1;
	logic [CMP_W-1:0]  pos_c;
	logic [CMP_W-1:0]  place_c;
	logic              at_pos;
	logic              past_pos;
	logic              in_list;

	// Place of this cell as a 1-based position, compared with the command
	assign pos_c    = CMP_W'(cmd.position);
	assign place_c  = CMP_W'(index) + CMP_W'(1);
	assign at_pos   = (place_c == pos_c);
	assign past_pos = (place_c > pos_c);
	assign in_list  = (CMP_W'(index) < CMP_W'(cmd.count));

	// Entry update: insert takes the new value or the lower neighbor,
	// delete takes the upper neighbor from the position on.
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (at_pos) begin
				entry_q <= cmd.value;
			end else if (past_pos) begin
				entry_q <= lower;
			end
		end else if (cmd.del) begin
			if (at_pos || past_pos) begin
				entry_q <= upper;
			end
		end
	end

	// Read selection and match flags, taken from the contents before the shift.
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			sel_data_s1 <= at_pos ? entry_q : '0;
			match_s1    <= in_list && (entry_q == cmd.value);
		end
	end

	assign entry    = entry_q;
	assign sel_data = sel_data_s1;
	assign match    = match_s1;

endmodule

`default_nettype wire

>>> rtl/pal_group.sv
// First level of the result tree: merges the read data of a group of cells
// and finds the lowest matching cell in the group. Depends on pal_pkg.
`default_nettype none

module pal_group (
	input  wire logic                                      clk,
	input  wire logic [pal_pkg::GROUP_N-1:0][pal_pkg::DATA_W-1:0] data,
	input  wire logic [pal_pkg::GROUP_N-1:0]               hit,
	output logic [pal_pkg::DATA_W-1:0]                     data_out,
	output logic                                           any_hit,
	output logic [pal_pkg::GIDX_W-1:0]                     hit_idx
);
	import pal_pkg::*;

	logic [DATA_W-1:0] data_c;
	logic [GIDX_W-1:0] idx_c;
	logic [DATA_W-1:0] data_s2;
	logic              hit_s2;
	logic [GIDX_W-1:0] idx_s2;

	// At most one cell drives nonzero data, so an OR merges them.
	// The downward scan leaves the lowest match.
	always_comb begin
		data_c = '0;
		idx_c  = '0;
		for (int k = 0; k < GROUP_N; k++) begin
			data_c = data_c | data[k];
		end
		for (int k = GROUP_N - 1; k >= 0; k--) begin
			if (hit[k]) begin
				idx_c = GIDX_W'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		data_s2 <= data_c;
		hit_s2  <= |hit;
		idx_s2  <= idx_c;
	end

	assign data_out = data_s2;
	assign any_hit  = hit_s2;
	assign hit_idx  = idx_s2;

endmodule

`default_nettype wire

>>> rtl/pal_checker.sv
// Port-level checks for the positional array list and the bind that
// attaches them to the top level. Depends on pal_pkg.
`default_nettype none

module pal_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cmd_valid,
	input  wire logic                       cmd_ready,
	input  wire logic                       res_valid,
	input  wire logic                       res_ready,
	input  wire logic [pal_pkg::STAT_W-1:0] res_status,
	input  wire logic [pal_pkg::DATA_W-1:0] res_read_value,
	input  wire logic [pal_pkg::POS_W-1:0]  res_found_position,
	input  wire logic [pal_pkg::LEN_W-1:0]  res_list_length,
	input  wire logic                       res_is_empty
);
	import pal_pkg::*;

	// A waiting result beat stays offered until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped before it was taken");

	// One command at a time: after a command beat the input closes.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command accepted while another is in progress");

	// The empty flag and the length agree, and the length stays within the list.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_is_empty == (res_list_length == '0)) &&
			(int'(res_list_length) <= CAPACITY))
		else $error("length and empty flag disagree");

	// A match lies inside the list.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_found_position <= res_list_length)
		else $error("match position beyond the list length");

	// A failed command returns no data and no match.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != ST_OK |-> res_read_value == '0 &&
			res_found_position == '0)
		else $error("failed command returned data");

endmodule

bind positional_array_list pal_checker u_pal_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.cmd_valid          (cmd.valid),
	.cmd_ready          (cmd.ready),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.res_status         (res.status),
	.res_read_value     (res.read_value),
	.res_found_position (res.found_position),
	.res_list_length    (res.list_length),
	.res_is_empty       (res.is_empty)
);

`default_nettype wire
